FILE: sv/cbm_pkg.sv
// cbm_pkg: shared types and constants of the cartridge bank mapper.
// Used by cbm_regs, cbm_xlate and cartridge_bank_mapper_irq; no dependencies.
package cbm_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE    = 2'd0,
      ACT_PRG_READ = 2'd1,
      ACT_CHR_READ = 2'd2,
      ACT_TICK     = 2'd3
   } cbm_action_type;

   typedef enum logic [1:0] {
      WIN_LOW   = 2'd0,
      WIN_SECOND = 2'd1,
      WIN_HIGH  = 2'd2,
      WIN_LAST  = 2'd3
   } cbm_window_type;

   localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
   localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
   localparam logic [1:0] MIRROR_ONE_LOW    = 2'd2;

   localparam logic [15:0] ADDR_PRG_FIRST  = 16'h8000;
   localparam logic [15:0] ADDR_PRG_SWAP   = 16'h9000;
   localparam logic [15:0] ADDR_MIRROR     = 16'h9001;
   localparam logic [15:0] ADDR_IRQ_CTRL   = 16'h9003;
   localparam logic [15:0] ADDR_IRQ_RELOAD = 16'h9004;
   localparam logic [15:0] ADDR_RELOAD_HI  = 16'h9005;
   localparam logic [15:0] ADDR_RELOAD_LO  = 16'h9006;
   localparam logic [15:0] ADDR_PRG_SECOND = 16'hA000;
   localparam logic [15:0] ADDR_CHR_BASE   = 16'hB000;

   localparam logic [7:0] FIXED_SWAP_BANK = 8'h3E;
   localparam logic [7:0] FIXED_LAST_BANK = 8'h3F;

   localparam int PRG_OFFSET_W = 13;
   localparam int CHR_OFFSET_W = 10;
   localparam int PRG_ADDR_W   = 21;
   localparam int CHR_ADDR_W   = 18;

   typedef struct packed {
      cbm_action_type action;
      logic [15:0]    bus_address;
      logic [7:0]     write_data;
   } cbm_item_type;

   // Register view handed from the state block to the translator/result stage.
   typedef struct packed {
      logic [7:0] prg_first;
      logic [7:0] prg_second;
      logic       prg_swap;
      logic [1:0] mirror_next;
      logic       irq_next;
   } cbm_view_type;

endpackage

FILE: sv/cbm_regs.sv
// cbm_regs: mapper register file, write decode and IRQ down-counter.
// Depends on cbm_pkg.
module cbm_regs #(
   parameter int CHR_BANK_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  cbm_pkg::cbm_item_type               item,
   output cbm_pkg::cbm_view_type               view,
   output logic [CHR_BANK_COUNT-1:0][7:0]      chr_banks
);

   localparam int IDX_W = $clog2(CHR_BANK_COUNT);

   logic [7:0]  prg_first_ff,  prg_first_in;
   logic [7:0]  prg_second_ff, prg_second_in;
   logic        prg_swap_ff,   prg_swap_in;
   logic [1:0]  mirror_ff,     mirror_in;
   logic        irq_enable_ff, irq_enable_in;
   logic [15:0] irq_count_ff,  irq_count_in;
   logic [15:0] irq_reload_ff, irq_reload_in;
   logic        irq_pending_ff, irq_pending_in;
   logic [CHR_BANK_COUNT-1:0][7:0] chr_banks_ff, chr_banks_in;

   logic        chr_hit;
   logic [15:0] count_dec;

   assign chr_hit   = (item.bus_address >> IDX_W) == (cbm_pkg::ADDR_CHR_BASE >> IDX_W);
   assign count_dec = irq_count_ff - 16'd1;

   always_comb begin
      prg_first_in   = prg_first_ff;
      prg_second_in  = prg_second_ff;
      prg_swap_in    = prg_swap_ff;
      mirror_in      = mirror_ff;
      irq_enable_in  = irq_enable_ff;
      irq_count_in   = irq_count_ff;
      irq_reload_in  = irq_reload_ff;
      irq_pending_in = irq_pending_ff;
      chr_banks_in   = chr_banks_ff;
      if (item.action == cbm_pkg::ACT_WRITE) begin
         priority if (chr_hit) begin
            chr_banks_in[item.bus_address[IDX_W-1:0]] = item.write_data;
         end else begin
            unique case (item.bus_address)
               cbm_pkg::ADDR_PRG_FIRST:  prg_first_in  = item.write_data;
               cbm_pkg::ADDR_PRG_SECOND: prg_second_in = item.write_data;
               cbm_pkg::ADDR_PRG_SWAP:   prg_swap_in   = item.write_data[7];
               cbm_pkg::ADDR_MIRROR: begin
                  priority if (item.write_data[6]) mirror_in = cbm_pkg::MIRROR_ONE_LOW;
                  else if (item.write_data[7])     mirror_in = cbm_pkg::MIRROR_HORIZONTAL;
                  else                             mirror_in = cbm_pkg::MIRROR_VERTICAL;
               end
               cbm_pkg::ADDR_IRQ_CTRL: begin
                  irq_enable_in  = item.write_data[7];
                  irq_pending_in = 1'b0;
               end
               cbm_pkg::ADDR_IRQ_RELOAD: begin
                  irq_count_in   = irq_reload_ff;
                  irq_pending_in = 1'b0;
               end
               cbm_pkg::ADDR_RELOAD_HI: irq_reload_in[15:8] = item.write_data;
               cbm_pkg::ADDR_RELOAD_LO: irq_reload_in[7:0]  = item.write_data;
               default: ;
            endcase
         end
      end else if (item.action == cbm_pkg::ACT_TICK) begin
         // counter parks at zero; the step into zero latches the IRQ
         if (irq_enable_ff && (irq_count_ff != 16'd0)) begin
            irq_count_in = count_dec;
            if (count_dec == 16'd0) irq_pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_first_ff   <= 8'd0;
         prg_second_ff  <= 8'd1;
         prg_swap_ff    <= 1'b0;
         mirror_ff      <= cbm_pkg::MIRROR_VERTICAL;
         irq_enable_ff  <= 1'b0;
         irq_count_ff   <= 16'd0;
         irq_reload_ff  <= 16'd0;
         irq_pending_ff <= 1'b0;
         for (int i = 0; i < CHR_BANK_COUNT; i++) begin
            chr_banks_ff[i] <= 8'(i);
         end
      end else if (step) begin
         prg_first_ff   <= prg_first_in;
         prg_second_ff  <= prg_second_in;
         prg_swap_ff    <= prg_swap_in;
         mirror_ff      <= mirror_in;
         irq_enable_ff  <= irq_enable_in;
         irq_count_ff   <= irq_count_in;
         irq_reload_ff  <= irq_reload_in;
         irq_pending_ff <= irq_pending_in;
         chr_banks_ff   <= chr_banks_in;
      end
   end

   assign view.prg_first   = prg_first_ff;
   assign view.prg_second  = prg_second_ff;
   assign view.prg_swap    = prg_swap_ff;
   assign view.mirror_next = mirror_in;
   assign view.irq_next    = irq_pending_in;
   assign chr_banks        = chr_banks_ff;

endmodule

FILE: sv/cbm_xlate.sv
// cbm_xlate: program and CHR address translation for read transfers.
// Depends on cbm_pkg.
module cbm_xlate #(
   parameter int CHR_BANK_COUNT = 8
) (
   input  cbm_pkg::cbm_item_type                    item,
   input  cbm_pkg::cbm_view_type                    view,
   input  logic [CHR_BANK_COUNT-1:0][7:0]           chr_banks,
   output logic [cbm_pkg::PRG_ADDR_W-1:0]           prg_rom_address,
   output logic [cbm_pkg::CHR_ADDR_W-1:0]           chr_rom_address
);

   localparam int IDX_W = $clog2(CHR_BANK_COUNT);

   cbm_pkg::cbm_window_type window;
   logic [7:0] prg_bank;
   logic [7:0] chr_bank;

   assign window   = cbm_pkg::cbm_window_type'(item.bus_address[14:13]);
   assign chr_bank = chr_banks[item.bus_address[cbm_pkg::CHR_OFFSET_W +: IDX_W]];

   always_comb begin
      unique case (window)
         cbm_pkg::WIN_LOW:    prg_bank = view.prg_swap ? cbm_pkg::FIXED_SWAP_BANK
                                                       : view.prg_first;
         cbm_pkg::WIN_SECOND: prg_bank = view.prg_second;
         cbm_pkg::WIN_HIGH:   prg_bank = view.prg_swap ? view.prg_first
                                                       : cbm_pkg::FIXED_SWAP_BANK;
         default:             prg_bank = cbm_pkg::FIXED_LAST_BANK;
      endcase
   end

   always_comb begin
      prg_rom_address = '0;
      chr_rom_address = '0;
      if (item.action == cbm_pkg::ACT_PRG_READ) begin
         prg_rom_address = {prg_bank, item.bus_address[cbm_pkg::PRG_OFFSET_W-1:0]};
      end
      if (item.action == cbm_pkg::ACT_CHR_READ) begin
         chr_rom_address = {chr_bank, item.bus_address[cbm_pkg::CHR_OFFSET_W-1:0]};
      end
   end

endmodule

FILE: sv/cartridge_bank_mapper_irq.sv
// cartridge_bank_mapper_irq: top level of the bank mapper with IRQ counter.
// Depends on cbm_pkg, cbm_regs and cbm_xlate.
//
// Usage:
//  - req_ channel: one transfer per CPU cycle event: a CPU write, a CPU program
//    read, a video CHR read, or a counter tick (req_action).
//  - rsp_ channel: exactly one transfer per request, in order: translated
//    program/CHR ROM byte addresses (zero when not that kind of read), plus the
//    mirroring mode and IRQ line as they stand after the request.
//  - Path: a request is held in the input register, then moves into the result
//    register, which is loaded while the mapper state updates; rsp_valid rises
//    once the result register holds it.
//  - Throughput: 1 request per cycle sustained while rsp_ready is high; set by
//    the single update of the register file between input and result registers.
//  - Stall: when rsp_ready is low the result register holds, the input register
//    fills, and req_ready drops only once both are full; no transfer is lost.
//  - Reset (synchronous, active high): both stages empty, banks at power-up
//    values (program 0/1, CHR bank i = i), vertical mirroring, counter, reload,
//    enable and pending IRQ cleared.
module cartridge_bank_mapper_irq #(
   parameter int CHR_BANK_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [15:0]                     req_bus_address,
   input  logic [7:0]                      req_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cbm_pkg::PRG_ADDR_W-1:0]  rsp_prg_rom_address,
   output logic [cbm_pkg::CHR_ADDR_W-1:0]  rsp_chr_rom_address,
   output logic [1:0]                      rsp_mirroring,
   output logic                            rsp_irq_line
);

   // input stage
   logic                  in_valid_ff, in_valid_in;
   cbm_pkg::cbm_item_type in_item_ff;
   // result stage
   logic                  out_valid_ff, out_valid_in;

   logic step;
   logic out_free;

   cbm_pkg::cbm_view_type          view;
   logic [CHR_BANK_COUNT-1:0][7:0] chr_banks;
   logic [cbm_pkg::PRG_ADDR_W-1:0] prg_xlate_addr;
   logic [cbm_pkg::CHR_ADDR_W-1:0] chr_addr;

   // result register can take a new item when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   // held item moves into the result register and commits its state update
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.action      <= cbm_pkg::cbm_action_type'(req_action);
         in_item_ff.bus_address <= req_bus_address;
         in_item_ff.write_data  <= req_write_data;
      end
   end

   cbm_regs #(
      .CHR_BANK_COUNT(CHR_BANK_COUNT)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .view      (view),
      .chr_banks (chr_banks)
   );

   cbm_xlate #(
      .CHR_BANK_COUNT(CHR_BANK_COUNT)
   ) u_xlate (
      .item            (in_item_ff),
      .view            (view),
      .chr_banks       (chr_banks),
      .prg_rom_address (prg_xlate_addr),
      .chr_rom_address (chr_addr)
   );

   // result payload, loaded with the state as it stands after the item
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_prg_rom_address <= prg_xlate_addr;
         rsp_chr_rom_address <= chr_addr;
         rsp_mirroring       <= view.mirror_next;
         rsp_irq_line        <= view.irq_next;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule
